// ===== rtl/core/printable_run_extractor_unit_macros.svh =====
// Assertion macros used by the printable run extractor front end.
`ifndef PRINTABLE_RUN_EXTRACTOR_UNIT_MACROS_SVH
`define PRINTABLE_RUN_EXTRACTOR_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PRE_ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the condition holds, the consequence must hold at the next clock edge.
`define PRE_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pre_pkg.sv =====
// Types, constants and helper functions of the printable run extractor.
package pre_pkg;

   localparam int unsigned MAX_MIN_LENGTH = 32;
   localparam int unsigned HOLD_W         = $clog2(MAX_MIN_LENGTH);
   localparam int unsigned LEN_W          = 6;
   localparam int unsigned POS_W          = 32;
   localparam int unsigned QUEUE_DEPTH    = 4;
   localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int unsigned ADDR_CHARS     = 10;
   localparam int unsigned ACNT_W         = $clog2(ADDR_CHARS);

   localparam logic [LEN_W-1:0] RUN_CAP      = 6'd63;
   localparam logic [LEN_W-1:0] MIN_LEN_RST  = 6'd6;
   localparam logic [7:0]       CHAR_SPACE   = 8'h20;
   localparam logic [7:0]       CHAR_DEL     = 8'h7F;
   localparam logic [7:0]       CHAR_TAB     = 8'h09;
   localparam logic [7:0]       CHAR_NEWLINE = 8'h0A;

   localparam logic [0:0] REG_MIN_LENGTH   = 1'b0;
   localparam logic [0:0] REG_SHOW_ADDRESS = 1'b1;

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_REPLAY,
      CMD_NEWLINE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [7:0]          data;
      logic [POS_W-1:0]    start;
      logic                show;
      logic [HOLD_W-1:0]   hold;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ADDR,
      BK_HELD_RD,
      BK_HELD,
      BK_CHAR
   } back_state_type;

   function automatic logic is_printable(input logic [7:0] b);
      return ((b >= CHAR_SPACE) && (b < CHAR_DEL)) || (b == CHAR_TAB);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      unique case (nib)
         4'h0: c = "0";
         4'h1: c = "1";
         4'h2: c = "2";
         4'h3: c = "3";
         4'h4: c = "4";
         4'h5: c = "5";
         4'h6: c = "6";
         4'h7: c = "7";
         4'h8: c = "8";
         4'h9: c = "9";
         4'hA: c = "A";
         4'hB: c = "B";
         4'hC: c = "C";
         4'hD: c = "D";
         4'hE: c = "E";
         default: c = "F";
      endcase
      return c;
   endfunction

   // State in which the back end starts work on a freshly loaded command.
   function automatic back_state_type first_state(input cmd_type c);
      back_state_type s;
      priority if (c.kind == CMD_REPLAY && c.show) begin
         s = BK_ADDR;
      end else if (c.kind == CMD_REPLAY && c.hold != '0) begin
         s = BK_HELD_RD;
      end else begin
         s = BK_CHAR;
      end
      return s;
   endfunction

endpackage

// ===== rtl/core/pre_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pre_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pre_cmd_queue.sv =====
// Short command queue between the classifying front end and the output back end.
module pre_cmd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  pre_pkg::cmd_type push_cmd,
   input  logic            pop,
   output pre_pkg::cmd_type head,
   output logic            full,
   output logic            empty
);
   import pre_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

endmodule

// ===== rtl/core/pre_front.sv =====
// Front end: takes input bytes, tracks runs, stores held bytes and issues commands.
`include "printable_run_extractor_unit_macros.svh"

module pre_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [0:0]                   csr_index,
   input  logic [pre_pkg::LEN_W-1:0]    csr_wr_data,
   input  logic                         req_push,
   input  logic [7:0]                   req_in_byte,
   output logic                         req_full,
   input  logic                         q_full,
   input  logic                         held_done,
   output logic                         cmd_push,
   output pre_pkg::cmd_type             cmd,
   output logic                         ram_we,
   output logic [pre_pkg::HOLD_W-1:0]   ram_addr,
   output logic [7:0]                   ram_wdata
);
   import pre_pkg::*;

   logic [LEN_W-1:0]  min_length_ff;
   logic              show_address_ff;
   logic [POS_W-1:0]  stream_pos_ff, stream_pos_in;
   logic [LEN_W-1:0]  run_length_ff, run_length_in;
   logic [POS_W-1:0]  run_start_ff, run_start_in;
   logic              busy_ff, busy_in;

   logic              accept;
   logic              printable;
   logic [LEN_W-1:0]  eff_min;
   logic [HOLD_W-1:0] hold;
   logic [POS_W-1:0]  start_now;

   always_comb begin
      priority if (min_length_ff == '0) begin
         eff_min = LEN_W'(1);
      end else if (min_length_ff > LEN_W'(MAX_MIN_LENGTH)) begin
         eff_min = LEN_W'(MAX_MIN_LENGTH);
      end else begin
         eff_min = min_length_ff;
      end
   end

   assign hold      = HOLD_W'(eff_min - 1'b1);
   assign req_full  = q_full || busy_ff;
   assign accept    = req_push && !req_full;
   assign printable = is_printable(req_in_byte);
   assign start_now = (run_length_ff == '0) ? stream_pos_ff : run_start_ff;

   always_comb begin
      cmd_push       = 1'b0;
      cmd.kind       = CMD_PASS;
      cmd.data       = req_in_byte;
      cmd.start      = start_now;
      cmd.show       = show_address_ff;
      cmd.hold       = hold;
      ram_we         = 1'b0;
      ram_addr       = run_length_ff[HOLD_W-1:0];
      ram_wdata      = req_in_byte;
      run_length_in  = run_length_ff;
      run_start_in   = run_start_ff;
      stream_pos_in  = stream_pos_ff;
      if (accept) begin
         stream_pos_in = stream_pos_ff + 1'b1;
         if (printable) begin
            run_start_in = start_now;
            priority if (run_length_ff < {1'b0, hold}) begin
               ram_we = 1'b1;
            end else if (run_length_ff == {1'b0, hold}) begin
               cmd_push = 1'b1;
               cmd.kind = CMD_REPLAY;
            end else begin
               cmd_push = 1'b1;
            end
            if (run_length_ff != RUN_CAP) begin
               run_length_in = run_length_ff + 1'b1;
            end
         end else begin
            if (run_length_ff >= eff_min) begin
               cmd_push = 1'b1;
               cmd.kind = CMD_NEWLINE;
               cmd.data = CHAR_NEWLINE;
            end
            run_length_in = '0;
         end
      end
   end

   // The held bytes of a replay must be read out before a new run may overwrite them.
   always_comb begin
      busy_in = busy_ff;
      if (held_done) begin
         busy_in = 1'b0;
      end else if (cmd_push && cmd.kind == CMD_REPLAY && cmd.hold != '0) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff   <= MIN_LEN_RST;
         show_address_ff <= 1'b0;
         stream_pos_ff   <= '0;
         run_length_ff   <= '0;
         run_start_ff    <= '0;
         busy_ff         <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_MIN_LENGTH:   min_length_ff   <= csr_wr_data;
               REG_SHOW_ADDRESS: show_address_ff <= csr_wr_data[0];
               default:          min_length_ff   <= min_length_ff;
            endcase
         end
         stream_pos_ff <= stream_pos_in;
         run_length_ff <= run_length_in;
         run_start_ff  <= run_start_in;
         busy_ff       <= busy_in;
      end
   end

   `PRE_ASSERT_ALWAYS(a_no_write_during_replay, clock, reset, !(ram_we && busy_ff),
      "held byte written while a replay is still reading them")
   `PRE_ASSERT_ALWAYS(a_write_below_hold, clock, reset,
      !ram_we || ({1'b0, ram_addr} < {1'b0, hold}), "held byte written beyond the hold count")
   `PRE_ASSERT_NEXT(a_replay_sets_busy, clock, reset,
      cmd_push && cmd.kind == CMD_REPLAY && cmd.hold != '0, busy_ff && req_full,
      "replay with held bytes did not stall the input")
   `PRE_ASSERT_ALWAYS(a_no_push_when_full, clock, reset, !(cmd_push && q_full),
      "command pushed into a full queue")

endmodule

// ===== rtl/core/pre_back.sv =====
// Back end: expands commands into output characters and holds the result register.
module pre_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  pre_pkg::cmd_type             q_head,
   output logic                         q_pop,
   output logic                         ram_rd_en,
   output logic [pre_pkg::HOLD_W-1:0]   ram_rd_addr,
   input  logic [7:0]                   ram_rd_data,
   output logic                         held_done,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_last
);
   import pre_pkg::*;

   back_state_type    state_ff, state_in;
   cmd_type           cur_ff, cur_in;
   logic [ACNT_W-1:0] acnt_ff, acnt_in;
   logic [HOLD_W-1:0] k_ff, k_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic              slot_free;
   logic              emit;
   logic [7:0]        emit_char;
   logic              emit_last;
   logic              load;
   logic [2:0]        digit_idx;
   logic [3:0]        nibble;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign digit_idx = 3'd7 - acnt_ff[2:0];
   assign nibble    = cur_ff.start[{digit_idx, 2'b00} +: 4];

   // Outputs of the sequencer.
   always_comb begin
      emit        = 1'b0;
      emit_char   = cur_ff.data;
      emit_last   = 1'b0;
      q_pop       = 1'b0;
      load        = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = k_ff;
      held_done   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               load  = 1'b1;
            end
         end
         BK_ADDR: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_char = (acnt_ff < ACNT_W'(8)) ? hex_char(nibble) : CHAR_SPACE;
            end
         end
         BK_HELD_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
         end
         BK_HELD: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_char = ram_rd_data;
               if (k_ff == cur_ff.hold - 1'b1) begin
                  held_done = 1'b1;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = k_ff + 1'b1;
               end
            end
         end
         BK_CHAR: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               if (!q_empty) begin
                  q_pop = 1'b1;
                  load  = 1'b1;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (load) begin
               state_in = first_state(q_head);
            end
         end
         BK_ADDR: begin
            if (emit && acnt_ff == ACNT_W'(ADDR_CHARS - 1)) begin
               state_in = (cur_ff.hold != '0) ? BK_HELD_RD : BK_CHAR;
            end
         end
         BK_HELD_RD: begin
            state_in = BK_HELD;
         end
         BK_HELD: begin
            if (held_done) begin
               state_in = BK_CHAR;
            end
         end
         BK_CHAR: begin
            if (emit) begin
               state_in = load ? first_state(q_head) : BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      cur_in  = load ? q_head : cur_ff;
      acnt_in = acnt_ff;
      k_in    = k_ff;
      if (load) begin
         acnt_in = '0;
      end else if (state_ff == BK_ADDR && emit) begin
         acnt_in = acnt_ff + 1'b1;
      end
      if (state_ff == BK_HELD_RD) begin
         k_in = '0;
      end else if (state_ff == BK_HELD && emit && !held_done) begin
         k_in = k_ff + 1'b1;
      end
      out_valid_in = emit || (out_valid_ff && !rsp_pop);
      out_byte_in  = emit ? emit_char : out_byte_ff;
      out_last_in  = emit ? emit_last : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         acnt_ff      <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         acnt_ff      <= acnt_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;

endmodule

// ===== rtl/core/printable_run_extractor_unit.sv =====
// Top level of the printable run extractor: front end, command queue, held-byte RAM, back end.
//
// Usage: raw bytes enter through a queue-like port (req_push, req_full, req_in_byte); a byte is
// taken at a clock edge with req_push high and req_full low. Text characters leave through a
// queue-like port (rsp_empty, rsp_pop, rsp_out_byte, rsp_last): the oldest character is shown
// while rsp_empty is low and is taken at an edge with rsp_pop high. rsp_last marks the final
// character caused by one input byte. csr_wr_en, csr_index and csr_wr_data write min_length
// (index 0) and show_address (index 1); write them only while the block is idle.
// A pass-through character goes through the command queue, the sequencer's command register
// and the output register before it is shown. Throughput: one byte per cycle while bytes pass
// straight through or are held and req_full stays low. A byte that completes a minimum-length
// run gives ten characters for the optional offset prefix, one per held byte and one for itself;
// a first held-byte RAM read comes before the held bytes. If there are held bytes, the input
// stalls from that byte until the last one is in the output register: the next run reuses the RAM.
// Between the classifier and the output sequencer sits a four-entry command queue.
// A stalled receiver fills the output register, then the command queue, then raises req_full;
// nothing is lost. Reset clears all control state, restores min_length 6 and show_address 0,
// and sets the stream offset to zero; the held-byte RAM keeps its contents and needs no clearing.
module printable_run_extractor_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [0:0]                csr_index,
   input  logic [pre_pkg::LEN_W-1:0] csr_wr_data,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [7:0]                req_in_byte,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last
);
   import pre_pkg::*;

   logic              cmd_push;
   cmd_type           cmd;
   cmd_type           q_head;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;
   logic              held_done;
   logic              ram_we;
   logic [HOLD_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wdata;
   logic              ram_rd_en;
   logic [HOLD_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   pre_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_full    (req_full),
      .q_full      (q_full),
      .held_done   (held_done),
      .cmd_push    (cmd_push),
      .cmd         (cmd),
      .ram_we      (ram_we),
      .ram_addr    (ram_wr_addr),
      .ram_wdata   (ram_wdata)
   );

   pre_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   pre_ram #(
      .WIDTH (8),
      .DEPTH (MAX_MIN_LENGTH)
   ) u_held_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pre_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .held_done    (held_done),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== sim/printable_run_extractor_unit_tb.sv =====
// Self-checking testbench for the printable run extractor unit.
`timescale 1ns / 100ps

module printable_run_extractor_unit_tb;

   localparam int CLOCK_HALF     = 4;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_OFF_LEN   = 200;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_ITEMS   = 260;
   localparam int MAX_REPORTS    = 10;
   localparam int LEN_W          = pre_pkg::LEN_W;
   localparam int MAX_MIN        = pre_pkg::MAX_MIN_LENGTH;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [0:0]       csr_index;
   logic [LEN_W-1:0] csr_wr_data;
   logic             req_push;
   logic             req_full;
   logic [7:0]       req_in_byte;
   logic             rsp_empty;
   logic             rsp_pop;
   logic [7:0]       rsp_out_byte;
   logic             rsp_last;

   // Shadow copy of the block's state and registers.
   logic [LEN_W-1:0] min_len_cfg;
   logic             show_addr_cfg;
   logic [31:0]      stream_pos;
   logic [5:0]       run_len;
   logic [31:0]      run_start;
   logic [7:0]       held_text [MAX_MIN];

   text_char_type expected_chars[$];

   int  error_count   = 0;
   int  cycle_count   = 0;
   int  bytes_sent    = 0;
   int  chars_checked = 0;
   int  csr_writes    = 0;
   bit  idle_on       = 1'b1;
   bit  hold_off_req  = 1'b0;

   printable_run_extractor_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_in_byte  (req_in_byte),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters still expected",
                  cycle_count, expected_chars.size());
         $display("printable_run_extractor_unit_tb: done, errors");
         $finish;
      end
   end

   function automatic bit is_text_byte(input logic [7:0] b);
      return (b == pre_pkg::CHAR_TAB) || ((b >= pre_pkg::CHAR_SPACE) && (b < pre_pkg::CHAR_DEL));
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] d;
      if (n < 4'd10) begin
         d = "0" + 8'(n);
      end else begin
         d = "A" + 8'(n) - 8'd10;
      end
      return d;
   endfunction

   function automatic int effective_min_len();
      int m;
      m = int'(min_len_cfg);
      if (m < 1) m = 1;
      if (m > MAX_MIN) m = MAX_MIN;
      return m;
   endfunction

   // Works out the characters that one accepted byte produces and queues them.
   function automatic void predict_text(input logic [7:0] b);
      text_char_type burst[$];
      text_char_type c;
      int            eff;
      int            hold;
      eff  = effective_min_len();
      hold = eff - 1;
      c.last = 1'b0;
      if (is_text_byte(b)) begin
         if (run_len == 0) run_start = stream_pos;
         if (int'(run_len) < hold) begin
            held_text[run_len[4:0]] = b;
         end else begin
            if (int'(run_len) == hold) begin
               if (show_addr_cfg) begin
                  for (int i = 7; i >= 0; i--) begin
                     c.ch = hex_digit(run_start[4*i +: 4]);
                     burst.push_back(c);
                  end
                  c.ch = pre_pkg::CHAR_SPACE;
                  burst.push_back(c);
                  burst.push_back(c);
               end
               for (int k = 0; k < hold; k++) begin
                  c.ch = held_text[k];
                  burst.push_back(c);
               end
            end
            c.ch = b;
            burst.push_back(c);
         end
         if (run_len < pre_pkg::RUN_CAP) run_len = run_len + 6'd1;
      end else begin
         if (int'(run_len) >= eff) begin
            c.ch = pre_pkg::CHAR_NEWLINE;
            burst.push_back(c);
         end
         run_len = '0;
      end
      stream_pos = stream_pos + 32'd1;
      foreach (burst[i]) begin
         burst[i].last = (i == burst.size() - 1);
         expected_chars.push_back(burst[i]);
      end
   endfunction

   function automatic void note_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endfunction

   // Compares every result transaction with the oldest expected character.
   always @(posedge clock) begin
      text_char_type exp_c;
      if (!reset && rsp_pop && !rsp_empty) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            note_mismatch($sformatf("unexpected char 0x%02h last %0b", rsp_out_byte, rsp_last));
         end else begin
            exp_c = expected_chars.pop_front();
            if (rsp_out_byte !== exp_c.ch) begin
               note_mismatch($sformatf("out_byte expected 0x%02h, got 0x%02h",
                                       exp_c.ch, rsp_out_byte));
            end
            if (rsp_last !== exp_c.last) begin
               note_mismatch($sformatf("last expected %0b, got %0b (char 0x%02h)",
                                       exp_c.last, rsp_last, exp_c.ch));
            end
         end
      end
   end

   // Receiver: pops whenever it can, with short random stalls and one long hold-off on request.
   initial begin
      rsp_pop = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_pop = 1'b0;
            repeat (HOLD_OFF_LEN) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_pop = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_pop = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offers one byte and waits for its transaction; returns at a falling edge with push still high.
   task automatic send_byte(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_push = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_push    = 1'b1;
      req_in_byte = b;
      do @(posedge clock); while (req_full);
      predict_text(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_text_byte();
      int v;
      v = $urandom_range(0, 95);
      return (v == 95) ? pre_pkg::CHAR_TAB : 8'(v) + pre_pkg::CHAR_SPACE;
   endfunction

   function automatic logic [7:0] rand_binary_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (is_text_byte(b));
      return b;
   endfunction

   task automatic send_run(input int n);
      for (int i = 0; i < n; i++) send_byte(rand_text_byte());
   endtask

   // Stops offering bytes and waits until every expected character has been taken.
   task automatic wait_idle();
      req_push = 1'b0;
      while (expected_chars.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [LEN_W-1:0] value);
      wait_idle();
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == pre_pkg::REG_MIN_LENGTH) begin
         min_len_cfg = value;
      end else begin
         show_addr_cfg = value[0];
      end
      csr_writes++;
   endtask

   // Reset settings: short runs, tab, the printable bounds and non-printable extremes.
   task automatic test_reset_defaults();
      send_text("Hi");
      send_byte(8'h00);
      send_byte(pre_pkg::CHAR_TAB);
      send_text("ABCD~");
      send_byte(pre_pkg::CHAR_SPACE);
      send_byte(pre_pkg::CHAR_DEL);
      send_byte(8'h1F);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_text("Hello");
      send_byte(pre_pkg::CHAR_NEWLINE);
   endtask

   // Largest minimum with the offset prefix gives the longest burst; a long run saturates the count.
   task automatic test_longest_run();
      write_reg(pre_pkg::REG_MIN_LENGTH, LEN_W'(MAX_MIN));
      write_reg(pre_pkg::REG_SHOW_ADDRESS, 6'h01);
      send_run(70);
      send_byte(8'h00);
      write_reg(pre_pkg::REG_MIN_LENGTH, 6'h3F);
      send_run(33);
      send_byte(8'hFF);
   endtask

   // A minimum of zero acts as one; upper data bits of the address switch are ignored.
   task automatic test_register_extremes();
      write_reg(pre_pkg::REG_MIN_LENGTH, 6'h00);
      write_reg(pre_pkg::REG_SHOW_ADDRESS, 6'h3F);
      send_text("ab");
      send_byte(8'hFF);
      send_text("z");
      send_byte(8'h00);
      write_reg(pre_pkg::REG_SHOW_ADDRESS, 6'h3E);
      send_text("cd");
      send_byte(8'h0D);
   endtask

   // Minimum raised and lowered while a run is still open.
   task automatic test_min_change_mid_run();
      write_reg(pre_pkg::REG_MIN_LENGTH, 6'd4);
      write_reg(pre_pkg::REG_SHOW_ADDRESS, 6'h01);
      send_run(6);
      // The replay after the raise reads entries left from earlier runs.
      write_reg(pre_pkg::REG_MIN_LENGTH, 6'd10);
      send_run(5);
      send_byte(8'h00);
      send_run(5);
      // Run is already past the new minimum, so its held bytes are dropped.
      write_reg(pre_pkg::REG_MIN_LENGTH, 6'd3);
      send_run(4);
      send_byte(8'h7F);
   endtask

   // Receiver holds off while every byte produces output, so the block must stall its input.
   task automatic test_backpressure();
      write_reg(pre_pkg::REG_MIN_LENGTH, 6'd1);
      write_reg(pre_pkg::REG_SHOW_ADDRESS, 6'h01);
      hold_off_req = 1'b1;
      for (int i = 0; i < 40; i++) begin
         if (i % 8 == 7) send_byte(rand_binary_byte());
         else send_byte(rand_text_byte());
      end
   endtask

   // Random phases: mostly well-formed runs around the minimum, some raw noise.
   task automatic test_random_stream(input int n_items);
      int sent;
      int phase_items;
      int sel;
      int eff;
      int len;
      sent = 0;
      while (sent < n_items) begin
         if (sent >= n_items - 80) idle_on = 1'b0;
         sel = $urandom_range(0, 9);
         case (sel)
            0:       write_reg(pre_pkg::REG_MIN_LENGTH, 6'd0);
            1:       write_reg(pre_pkg::REG_MIN_LENGTH, LEN_W'($urandom_range(33, 63)));
            2:       write_reg(pre_pkg::REG_MIN_LENGTH, LEN_W'(MAX_MIN));
            default: write_reg(pre_pkg::REG_MIN_LENGTH, LEN_W'($urandom_range(1, 8)));
         endcase
         write_reg(pre_pkg::REG_SHOW_ADDRESS, LEN_W'($urandom));
         eff = effective_min_len();
         phase_items = 0;
         while (phase_items < 40 && sent < n_items) begin
            if ($urandom_range(0, 6) == 0) begin
               len = $urandom_range(1, 8);
               for (int i = 0; i < len; i++) send_byte(8'($urandom));
            end else begin
               len = ($urandom_range(0, 15) == 0) ? $urandom_range(eff, 70)
                                                  : $urandom_range(0, eff + 4);
               send_run(len);
               send_byte(rand_binary_byte());
               len = len + 1;
            end
            phase_items += len;
            sent        += len;
         end
      end
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wr_data = '0;
      req_push    = 1'b0;
      req_in_byte = '0;
      min_len_cfg   = pre_pkg::MIN_LEN_RST;
      show_addr_cfg = 1'b0;
      stream_pos    = '0;
      run_len       = '0;
      run_start     = '0;
      foreach (held_text[i]) held_text[i] = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_longest_run();
      test_register_extremes();
      test_min_change_mid_run();
      test_backpressure();
      test_random_stream(RANDOM_ITEMS);

      wait_idle();
      repeat (20) @(negedge clock);
      $display("covered %0d input bytes and %0d output characters with %0d register writes,",
               bytes_sent, chars_checked, csr_writes);
      $display("including offset prefixes, mid-run minimum changes and a long output stall");
      if (error_count == 0) begin
         $display("printable_run_extractor_unit_tb: done, clean");
      end else begin
         $display("%0d mismatches in total", error_count);
         $display("printable_run_extractor_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
